// ===== rtl/cset_pkg.sv =====
// Shared codes and widths for the contact set event tracker.
// No dependencies; imported by the core, the slot RAM and the checker.
package cset_pkg;

  localparam int PARTNER_W   = 16;
  localparam int CODE_W      = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef logic [CODE_W-1:0] event_code_t;

  localparam event_code_t EV_NONE  = 3'd0;
  localparam event_code_t EV_ENTER = 3'd1;
  localparam event_code_t EV_STAY  = 3'd2;
  localparam event_code_t EV_EXIT  = 3'd3;
  localparam event_code_t EV_FULL  = 3'd4;

endpackage

// ===== rtl/cset_slot_ram.sv =====
// Single-port-write, single-port-read slot memory with registered read data.
// Depends on cset_pkg only through the common import convention.
module cset_slot_ram
  import cset_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/contact_set_event_tracker_core.sv =====
// Contact set event tracker: top level with scan sequencer, valid bits and
// output register. Depends on cset_pkg and cset_slot_ram.
//
// Usage:
//   Input beats carry one partner identifier (in_tdata) and a hit flag
//   (in_tuser). Each accepted beat produces exactly one output beat with an
//   event code and the partner it concerns: enter, stay, exit, none, or full
//   when a new partner finds every slot occupied (the identifier is dropped).
//   Partner identifiers live in a slot RAM with registered read data;
//   the occupancy of each slot is held in a flip-flop valid bit.
//   Pacing: a new beat is accepted only after the previous one is decided.
//   The scan reads one slot per cycle from the single RAM read port and
//   compares each slot after its registered read; a final decision state
//   applies the decision and writes back.
//   Only one beat is in progress at a time, so RAM writes never overlap a
//   scan of the same entry.
//   Stall: a finished result waits in the output register; the next input
//   beat is accepted and scanned meanwhile, and its decision waits until the
//   output register is free.
//   Reset (rst_n low, synchronous): the set is emptied at once through the
//   valid bits and the output valid bit is cleared; no clearing pass.
module contact_set_event_tracker_core
  import cset_pkg::*;
#(
  parameter int SET_CAPACITY = 16,
  parameter int ID_BITS      = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] partner_id
  input  logic                   in_tuser,   // [0] is_hit
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [2:0] event_code, [18:3] event_partner
);

  // Stored key width: identifiers are masked to ID_BITS, but never exceed the port
  localparam int KEY_W = (ID_BITS < PARTNER_W) ? ID_BITS : PARTNER_W;
  localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CNT_W = $clog2(SET_CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SET_CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SET_CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [SET_CAPACITY-1:0] valid_r;
  logic [KEY_W-1:0]        key_r;
  logic                    hit_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    rd_pend_r;
  logic [IDX_W-1:0]        cmp_idx_r;
  logic                    found_r;
  logic [IDX_W-1:0]        found_idx_r;
  logic                    free_r;
  logic [IDX_W-1:0]        free_idx_r;
  logic                    out_valid_r;
  event_code_t             out_code_r;
  logic [PARTNER_W-1:0]    out_partner_r;

  logic                    in_fire;
  logic                    out_free;
  logic                    fin_go;
  logic                    rd_en;
  logic [KEY_W-1:0]        rd_data;
  logic                    wr_en;
  event_code_t             code_nxt;
  logic [PARTNER_W-1:0]    partner_ext;
  logic [PARTNER_W-1:0]    partner_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign fin_go    = (state_r == S_FIN) && out_free;
  assign rd_en     = (state_r == S_SCAN) && (cnt_r != CNT_END);

  cset_slot_ram #(
    .DEPTH  (SET_CAPACITY),
    .WIDTH  (KEY_W),
    .ADDR_W (IDX_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx_r),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Sequencer: idle -> scan every slot -> decide and write back
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (rd_pend_r && (cmp_idx_r == LAST_IDX)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Decision once the scan has seen every slot
  always_comb begin
    partner_ext            = '0;
    partner_ext[KEY_W-1:0] = key_r;
    partner_nxt            = partner_ext;
    wr_en                  = 1'b0;
    if (hit_r) begin
      if (found_r) begin
        code_nxt = EV_STAY;
      end else if (free_r) begin
        code_nxt = EV_ENTER;
        wr_en    = fin_go;
      end else begin
        code_nxt = EV_FULL;
      end
    end else begin
      if (found_r) begin
        code_nxt = EV_EXIT;
      end else begin
        code_nxt    = EV_NONE;
        partner_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Drop the output beat once taken, load a new one when deciding
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (in_fire) begin
        rd_pend_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        rd_pend_r <= rd_en;
      end

      // Occupancy: mark on enter, release on exit
      if (fin_go) begin
        if (hit_r && !found_r && free_r) begin
          valid_r[free_idx_r] <= 1'b1;
        end else if (!hit_r && found_r) begin
          valid_r[found_idx_r] <= 1'b0;
        end
      end
    end
  end

  // Scan datapath: issue one read per cycle, compare the slot read last cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r   <= in_tdata[KEY_W-1:0];
      hit_r   <= in_tuser;
      cnt_r   <= '0;
      found_r <= 1'b0;
      free_r  <= 1'b0;
    end else if (state_r == S_SCAN) begin
      if (rd_en) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end
      cmp_idx_r <= cnt_r[IDX_W-1:0];
      if (rd_pend_r) begin
        if (valid_r[cmp_idx_r] && (rd_data == key_r)) begin
          found_r     <= 1'b1;
          found_idx_r <= cmp_idx_r;
        end
        // keep the lowest free slot
        if (!valid_r[cmp_idx_r] && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= cmp_idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_code_r    <= code_nxt;
      out_partner_r <= partner_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_partner_r, out_code_r};

endmodule

// ===== rtl/cset_checker.sv =====
// Port-level checker for the contact set event tracker, bound to the core.
// Depends on cset_pkg for event codes and field widths.
module cset_checker
  import cset_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // The core takes one beat at a time: busy in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a beat is still being scanned");

  // Accepted input beats carry defined data
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !$isunknown({in_tdata, in_tuser}))
    else $error("input beat accepted with unknown data");

  // Only defined event codes leave the block
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] == EV_NONE) || (out_tdata[2:0] == EV_ENTER) ||
                   (out_tdata[2:0] == EV_STAY) || (out_tdata[2:0] == EV_EXIT) ||
                   (out_tdata[2:0] == EV_FULL))
    else $error("undefined event code");

  // A no-event result carries a zero partner and zero padding
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == EV_NONE) |-> (out_tdata[OUT_TDATA_W-1:3] == '0))
    else $error("no-event beat with non-zero partner");

endmodule

bind contact_set_event_tracker_core cset_checker u_cset_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
